### hw/rtl/pcu_pkg.sv
// ----------------------------------------------------------------------------
// pcu_pkg
// shared constants and types of the palindrome checker unit
// ----------------------------------------------------------------------------
package pcu_pkg;

    // store capacity, a string ends once STORE_SIZE-1 characters are stored
    localparam int STORE_SIZE = 128;
    localparam int CNT_W      = (STORE_SIZE > 2) ? $clog2(STORE_SIZE) : 1;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 7;

    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(STORE_SIZE - 1);

    typedef struct packed {
        logic               is_palindrome;
        logic [COUNT_W-1:0] char_count;
        logic               ended_by_full;
    } t_result;

endpackage

### hw/rtl/pcu_ram.sv
// ----------------------------------------------------------------------------
// pcu_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module pcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### hw/rtl/pcu_ctrl.sv
// ----------------------------------------------------------------------------
// pcu_ctrl
// character capture and two-pointer compare over the character store
// ----------------------------------------------------------------------------
module pcu_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [pcu_pkg::CHAR_W-1:0] i_char,
    output logic                       o_in_ready,
    output logic                       o_res_valid,
    output pcu_pkg::t_result           o_res,
    input  logic                       i_res_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [pcu_pkg::CNT_W-1:0]   r_count, n_count;
    logic [pcu_pkg::CNT_W-1:0]   r_len, n_len;
    logic [pcu_pkg::CNT_W-1:0]   r_lo, n_lo;
    logic [pcu_pkg::CNT_W-1:0]   r_hi, n_hi;
    logic                        r_full, n_full;
    logic                        r_pal, n_pal;

    logic                        w_we;
    logic [pcu_pkg::CNT_W-1:0]   w_cnt_inc;
    logic                        w_end;
    logic [pcu_pkg::CNT_W-1:0]   w_end_len;
    logic                        w_end_full;
    logic [pcu_pkg::CNT_W:0]     w_gap;
    logic [pcu_pkg::CHAR_W-1:0]  w_rd_lo;
    logic [pcu_pkg::CHAR_W-1:0]  w_rd_hi;

    pcu_ram #(
        .WIDTH (pcu_pkg::CHAR_W),
        .DEPTH (pcu_pkg::STORE_SIZE)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_count),
        .i_wdata   (i_char),
        .i_raddr_a (r_lo),
        .i_raddr_b (r_hi),
        .o_rdata_a (w_rd_lo),
        .o_rdata_b (w_rd_hi)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_cnt_inc  = r_count + 1'b1;
    assign w_gap      = {1'b0, r_hi} - {1'b0, r_lo};

    // capture side: spaces dropped, cr or a full store ends the string
    always_comb begin
        w_we       = 1'b0;
        w_end      = 1'b0;
        w_end_len  = r_count;
        w_end_full = 1'b0;
        if (i_in_valid && o_in_ready && (i_char != pcu_pkg::CHAR_SPACE)) begin
            if (i_char == pcu_pkg::CHAR_CR) begin
                w_end = 1'b1;
            end else begin
                w_we = 1'b1;
                if (w_cnt_inc == pcu_pkg::LAST_COUNT) begin
                    w_end      = 1'b1;
                    w_end_len  = w_cnt_inc;
                    w_end_full = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_len   = r_len;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_full  = r_full;
        n_pal   = r_pal;
        case (r_state)
            S_IDLE: begin
                if (w_we) begin
                    n_count = w_cnt_inc;
                end
                if (w_end) begin
                    n_count = '0;
                    n_len   = w_end_len;
                    n_full  = w_end_full;
                    n_lo    = '0;
                    n_hi    = w_end_len - 1'b1;
                    if (w_end_len < pcu_pkg::CNT_W'(2)) begin
                        n_pal   = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_rd_lo != w_rd_hi) begin
                    n_pal   = 1'b0;
                    n_state = S_OUT;
                end else if (w_gap > (pcu_pkg::CNT_W + 1)'(2)) begin
                    n_lo    = r_lo + 1'b1;
                    n_hi    = r_hi - 1'b1;
                    n_state = S_RD;
                end else begin
                    n_pal   = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_len  <= n_len;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_full <= n_full;
        r_pal  <= n_pal;
    end

    assign o_res_valid         = (r_state == S_OUT);
    assign o_res.is_palindrome = r_pal;
    assign o_res.char_count    = pcu_pkg::COUNT_W'(r_len);
    assign o_res.ended_by_full = r_full;

    a_ptr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_lo < r_hi))
        else $error("pointers crossed during compare");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < pcu_pkg::LAST_COUNT)
        else $error("stored count reached capacity without ending");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE))
        else $error("store written outside capture");

    a_cmp_follows_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_RD))
        else $error("compare without a read the cycle before");

endmodule

### hw/rtl/palindrome_checker_unit.sv
// ----------------------------------------------------------------------------
// palindrome_checker_unit
// stores a string one character an item, then walks two pointers inward
// ----------------------------------------------------------------------------
// a stored or skipped character is taken one item per cycle while the unit is idle;
// at a string end each compared pair passes a ram read state, then a compare state,
// until a mismatch or the pointers meet; no input is taken until the result is out
// the compare rate is set by the single two-port read of the character store
// reset (i_rst_n low, synchronous) clears the count, fsm and output valid flag;
// the character store itself is not cleared, only written entries are read
// ----------------------------------------------------------------------------
module palindrome_checker_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input item stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    // result stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] is_palindrome, [7:1] char_count
    output logic       m_axis_tuser    // [0] ended_by_full
);

    logic             w_res_valid;
    logic             w_res_ready;
    pcu_pkg::t_result w_res;

    logic             r_out_valid;
    pcu_pkg::t_result r_out;

    // capture and compare engine around the character store
    pcu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_char      (s_axis_tdata),
        .o_in_ready  (s_axis_tready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // output register: free when empty or being drained this cycle
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.char_count, r_out.is_palindrome};
    assign m_axis_tuser  = r_out.ended_by_full;

    // a result is handed over only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result overwritten");

    // no new string captured while the engine still owns a result
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !s_axis_tready)
        else $error("input accepted while a result is pending in the engine");

endmodule
